### design/uads_pkg.sv
`timescale 1ns / 1ps

package uads_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FREE_STREAM_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FREE_STREAM_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ADV_FACTOR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_FACTOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_MODE   = 3'd4;

    localparam logic signed [63:0] SAT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_LO = 64'shFFFF_FFFF_8000_0000;
    localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;

    // Rounding offsets for the two fixed-point scalings.
    localparam logic signed [63:0] HALF_LSB_16 = 64'sd32768;
    localparam logic signed [63:0] HALF_LSB_15 = 64'sd16384;

    typedef struct packed {
        logic signed [31:0] free_stream_x;
        logic signed [31:0] free_stream_y;
        logic signed [31:0] adv_factor;
        logic signed [31:0] diff_factor;
        logic               update_mode;
    } cfg_t;

    // One classified grid point, as handed from the front to the back.
    typedef struct packed {
        logic signed [31:0] a_sat;
        logic signed [31:0] b_sat;
        logic signed [31:0] dx_u;
        logic signed [31:0] dy_u;
        logic signed [31:0] dx_v;
        logic signed [31:0] dy_v;
        logic signed [31:0] lap_u;
        logic signed [31:0] lap_v;
        logic signed [32:0] base_u;
        logic signed [32:0] base_v;
    } point_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] r;
        if (x > SAT_HI)
        begin
            r = Q_MAX;
        end
        else if (x < SAT_LO)
        begin
            r = Q_MIN;
        end
        else
        begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

### design/uads_front.sv
`timescale 1ns / 1ps

module uads_front import uads_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [31:0]  u_center,
    input  logic signed [31:0]  u_east,
    input  logic signed [31:0]  u_west,
    input  logic signed [31:0]  u_north,
    input  logic signed [31:0]  u_south,
    input  logic signed [31:0]  v_center,
    input  logic signed [31:0]  v_east,
    input  logic signed [31:0]  v_west,
    input  logic signed [31:0]  v_north,
    input  logic signed [31:0]  v_south,
    input  logic signed [31:0]  prev_u,
    input  logic signed [31:0]  prev_v,
    input  cfg_t                cfg,
    input  queue_status_t       q_status,
    output logic                push,
    output point_t              push_item
);

    logic        front_valid_reg;
    logic        front_valid_next;
    point_t      item_reg;
    point_t      item_next;
    logic        take;

    logic signed [32:0] a;
    logic signed [32:0] b;
    logic               a_pos;
    logic               b_pos;
    logic signed [32:0] dx_u_raw;
    logic signed [32:0] dy_u_raw;
    logic signed [32:0] dx_v_raw;
    logic signed [32:0] dy_v_raw;
    logic signed [34:0] lap_u_raw;
    logic signed [34:0] lap_v_raw;

    assign busy = front_valid_reg && q_status.full;
    assign take = start && !busy;
    assign push = front_valid_reg && !q_status.full;
    assign push_item = item_reg;

    always_comb
    begin
        a = 33'(u_center) + 33'(cfg.free_stream_x);
        b = 33'(v_center) + 33'(cfg.free_stream_y);
        // A velocity of exactly zero takes the downwind-side difference.
        a_pos = !a[32] && (a != '0);
        b_pos = !b[32] && (b != '0);

        dx_u_raw = a_pos ? (33'(u_center) - 33'(u_west)) : (33'(u_east) - 33'(u_center));
        dy_u_raw = b_pos ? (33'(u_center) - 33'(u_south)) : (33'(u_north) - 33'(u_center));
        dx_v_raw = a_pos ? (33'(v_center) - 33'(v_west)) : (33'(v_east) - 33'(v_center));
        dy_v_raw = b_pos ? (33'(v_center) - 33'(v_south)) : (33'(v_north) - 33'(v_center));

        lap_u_raw = 35'(u_east) + 35'(u_north) + 35'(u_west) + 35'(u_south)
                  - (35'(u_center) <<< 2);
        lap_v_raw = 35'(v_east) + 35'(v_north) + 35'(v_west) + 35'(v_south)
                  - (35'(v_center) <<< 2);

        item_next.a_sat = sat32(64'(a));
        item_next.b_sat = sat32(64'(b));
        item_next.dx_u  = sat32(64'(dx_u_raw));
        item_next.dy_u  = sat32(64'(dy_u_raw));
        item_next.dx_v  = sat32(64'(dx_v_raw));
        item_next.dy_v  = sat32(64'(dy_v_raw));
        item_next.lap_u = sat32(64'(lap_u_raw));
        item_next.lap_v = sat32(64'(lap_v_raw));
        item_next.base_u = cfg.update_mode ? (33'(prev_u) - 33'(u_center)) : 33'(prev_u);
        item_next.base_v = cfg.update_mode ? (33'(prev_v) - 33'(v_center)) : 33'(prev_v);
    end

    always_comb
    begin
        if (take)
        begin
            front_valid_next = 1'b1;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
        else
        begin
            front_valid_next = front_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    // A transaction accepted while the queue is full must not overwrite a held point.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (front_valid_reg && q_status.full) |-> !take)
        else $error("front stage overwritten while held");

endmodule

### design/uads_queue.sv
`timescale 1ns / 1ps

module uads_queue import uads_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  point_t        push_item,
    input  logic          pop,
    output point_t        pop_item,
    output queue_status_t status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    point_t          entries_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   count_reg;
    logic [CW-1:0]   count_next;
    logic            do_push;
    logic            do_pop;

    assign status.full  = (count_reg == CW'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push = push && !status.full;
    assign do_pop  = pop && !status.empty;
    assign pop_item = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !status.full)
        else $error("push into a full queue");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue lost a point");

endmodule

### design/uads_back.sv
`timescale 1ns / 1ps

module uads_back import uads_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  queue_status_t       q_status,
    input  point_t              item,
    input  cfg_t                cfg,
    output logic                pop,
    output logic                done,
    output logic signed [31:0]  out_u,
    output logic signed [31:0]  out_v
);

    logic signed [31:0] a_sat;
    logic signed [31:0] b_sat;
    logic signed [31:0] dx_u;
    logic signed [31:0] dy_u;
    logic signed [31:0] dx_v;
    logic signed [31:0] dy_v;

    // Stage 1: velocity times upwind difference.
    logic               s1_valid_reg;
    logic signed [63:0] s1_px_u_reg, s1_px_u_next;
    logic signed [63:0] s1_py_u_reg, s1_py_u_next;
    logic signed [63:0] s1_px_v_reg, s1_px_v_next;
    logic signed [63:0] s1_py_v_reg, s1_py_v_next;
    logic signed [31:0] s1_lap_u_reg;
    logic signed [31:0] s1_lap_v_reg;
    logic signed [32:0] s1_base_u_reg;
    logic signed [32:0] s1_base_v_reg;

    // Stage 2: rounded and saturated advection sum.
    logic               s2_valid_reg;
    logic signed [31:0] s2_adv_u_reg, s2_adv_u_next;
    logic signed [31:0] s2_adv_v_reg, s2_adv_v_next;
    logic signed [31:0] s2_lap_u_reg;
    logic signed [31:0] s2_lap_v_reg;
    logic signed [32:0] s2_base_u_reg;
    logic signed [32:0] s2_base_v_reg;

    // Stage 3: weighting by the configured factors.
    logic               s3_valid_reg;
    logic signed [63:0] s3_pa_u_reg, s3_pa_u_next;
    logic signed [63:0] s3_pd_u_reg, s3_pd_u_next;
    logic signed [63:0] s3_pa_v_reg, s3_pa_v_next;
    logic signed [63:0] s3_pd_v_reg, s3_pd_v_next;
    logic signed [32:0] s3_base_u_reg;
    logic signed [32:0] s3_base_v_reg;

    // Stage 4: operator value.
    logic               s4_valid_reg;
    logic signed [63:0] s4_op_u_reg, s4_op_u_next;
    logic signed [63:0] s4_op_v_reg, s4_op_v_next;
    logic signed [32:0] s4_base_u_reg;
    logic signed [32:0] s4_base_v_reg;

    // Stage 5: output register.
    logic               s5_valid_reg;
    logic signed [31:0] out_u_reg, out_u_next;
    logic signed [31:0] out_v_reg, out_v_next;

    assign pop   = !q_status.empty;
    assign done  = s5_valid_reg;
    assign out_u = out_u_reg;
    assign out_v = out_v_reg;

    always_comb
    begin
        a_sat = item.a_sat;
        b_sat = item.b_sat;
        dx_u  = item.dx_u;
        dy_u  = item.dy_u;
        dx_v  = item.dx_v;
        dy_v  = item.dy_v;
        s1_px_u_next = a_sat * dx_u;
        s1_py_u_next = b_sat * dy_u;
        s1_px_v_next = a_sat * dx_v;
        s1_py_v_next = b_sat * dy_v;

        s2_adv_u_next = sat32(((s1_px_u_reg + HALF_LSB_16) >>> 16)
                            + ((s1_py_u_reg + HALF_LSB_16) >>> 16));
        s2_adv_v_next = sat32(((s1_px_v_reg + HALF_LSB_16) >>> 16)
                            + ((s1_py_v_reg + HALF_LSB_16) >>> 16));

        s3_pa_u_next = cfg.adv_factor * s2_adv_u_reg;
        s3_pd_u_next = cfg.diff_factor * s2_lap_u_reg;
        s3_pa_v_next = cfg.adv_factor * s2_adv_v_reg;
        s3_pd_v_next = cfg.diff_factor * s2_lap_v_reg;

        // The advection weight is applied doubled, so it is scaled down by 15 bits.
        s4_op_u_next = ((s3_pa_u_reg + HALF_LSB_15) >>> 15)
                     + ((s3_pd_u_reg + HALF_LSB_16) >>> 16);
        s4_op_v_next = ((s3_pa_v_reg + HALF_LSB_15) >>> 15)
                     + ((s3_pd_v_reg + HALF_LSB_16) >>> 16);

        out_u_next = sat32(64'(s4_base_u_reg) - s4_op_u_reg);
        out_v_next = sat32(64'(s4_base_v_reg) - s4_op_v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_px_u_reg   <= s1_px_u_next;
        s1_py_u_reg   <= s1_py_u_next;
        s1_px_v_reg   <= s1_px_v_next;
        s1_py_v_reg   <= s1_py_v_next;
        s1_lap_u_reg  <= item.lap_u;
        s1_lap_v_reg  <= item.lap_v;
        s1_base_u_reg <= item.base_u;
        s1_base_v_reg <= item.base_v;

        s2_adv_u_reg  <= s2_adv_u_next;
        s2_adv_v_reg  <= s2_adv_v_next;
        s2_lap_u_reg  <= s1_lap_u_reg;
        s2_lap_v_reg  <= s1_lap_v_reg;
        s2_base_u_reg <= s1_base_u_reg;
        s2_base_v_reg <= s1_base_v_reg;

        s3_pa_u_reg   <= s3_pa_u_next;
        s3_pd_u_reg   <= s3_pd_u_next;
        s3_pa_v_reg   <= s3_pa_v_next;
        s3_pd_v_reg   <= s3_pd_v_next;
        s3_base_u_reg <= s2_base_u_reg;
        s3_base_v_reg <= s2_base_v_reg;

        s4_op_u_reg   <= s4_op_u_next;
        s4_op_v_reg   <= s4_op_v_next;
        s4_base_u_reg <= s3_base_u_reg;
        s4_base_v_reg <= s3_base_v_reg;

        out_u_reg     <= out_u_next;
        out_v_reg     <= out_v_next;
    end

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(pop, 5))
        else $error("result without a matching queue pop");

endmodule

### design/upwind_advection_diffusion_stencil.sv
`timescale 1ns / 1ps

// Channel   | Handshake            | Payload
// ----------+----------------------+--------------------------------------------
// input     | start, busy          | u_center..u_south, v_center..v_south,
//           |                      | prev_u, prev_v
// result    | done (one cycle)     | out_u, out_v
// config    | cfg_we               | cfg_index, cfg_data
//
// One grid point is taken per clock cycle while busy is low; each accepted point passes, in order,
// through the front classification register, the point queue and the five-stage multiply,
// round and saturate pipeline of the back end, one result per accepted point.
// Reset clears the configuration registers to zero and empties the pipeline.
// The back end drains the queue every cycle, so busy stays low in normal use.
module upwind_advection_diffusion_stencil import uads_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic signed [31:0]    u_center,
    input  logic signed [31:0]    u_east,
    input  logic signed [31:0]    u_west,
    input  logic signed [31:0]    u_north,
    input  logic signed [31:0]    u_south,
    input  logic signed [31:0]    v_center,
    input  logic signed [31:0]    v_east,
    input  logic signed [31:0]    v_west,
    input  logic signed [31:0]    v_north,
    input  logic signed [31:0]    v_south,
    input  logic signed [31:0]    prev_u,
    input  logic signed [31:0]    prev_v,
    output logic                  done,
    output logic signed [31:0]    out_u,
    output logic signed [31:0]    out_v,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_data
);

    cfg_t          cfg_reg;
    cfg_t          cfg_next;
    queue_status_t q_status;
    logic          push;
    point_t        push_item;
    logic          pop;
    point_t        pop_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FREE_STREAM_X: cfg_next.free_stream_x = cfg_data;
                CFG_FREE_STREAM_Y: cfg_next.free_stream_y = cfg_data;
                CFG_ADV_FACTOR:    cfg_next.adv_factor    = cfg_data;
                CFG_DIFF_FACTOR:   cfg_next.diff_factor   = cfg_data;
                CFG_UPDATE_MODE:   cfg_next.update_mode   = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    uads_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .u_center  (u_center),
        .u_east    (u_east),
        .u_west    (u_west),
        .u_north   (u_north),
        .u_south   (u_south),
        .v_center  (v_center),
        .v_east    (v_east),
        .v_west    (v_west),
        .v_north   (v_north),
        .v_south   (v_south),
        .prev_u    (prev_u),
        .prev_v    (prev_v),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .push      (push),
        .push_item (push_item)
    );

    uads_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .status    (q_status)
    );

    uads_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .item     (pop_item),
        .cfg      (cfg_reg),
        .pop      (pop),
        .done     (done),
        .out_u    (out_u),
        .out_v    (out_v)
    );

endmodule

### tb/sv/upwind_stencil_checker.sv
`timescale 1ns / 1ps

module upwind_stencil_checker import uads_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic signed [31:0]    u_center,
    input  logic signed [31:0]    u_east,
    input  logic signed [31:0]    u_west,
    input  logic signed [31:0]    u_north,
    input  logic signed [31:0]    u_south,
    input  logic signed [31:0]    v_center,
    input  logic signed [31:0]    v_east,
    input  logic signed [31:0]    v_west,
    input  logic signed [31:0]    v_north,
    input  logic signed [31:0]    v_south,
    input  logic signed [31:0]    prev_u,
    input  logic signed [31:0]    prev_v,
    input  logic                  done,
    input  logic signed [31:0]    out_u,
    input  logic signed [31:0]    out_v,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]           cfg_data,
    output int unsigned           outstanding,
    output int unsigned           failures
);

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
    } velocity_t;

    velocity_t          expected_velocity_q[$];
    velocity_t          want;
    int unsigned        new_errors;

    logic signed [31:0] fs_x;
    logic signed [31:0] fs_y;
    logic signed [31:0] adv_w;
    logic signed [31:0] diff_w;
    logic               implicit_mode;

    function automatic longint clamp_q(input longint x);
        if (x > SAT_HI)
        begin
            return SAT_HI;
        end
        if (x < SAT_LO)
        begin
            return SAT_LO;
        end
        return x;
    endfunction

    // Round to nearest with ties toward plus infinity; the arithmetic shift floors.
    function automatic longint round_shift(input longint x, input int k);
        longint half;
        half = longint'(1) << (k - 1);
        return (x + half) >>> k;
    endfunction

    function automatic longint upwind_operator(input longint c, input longint e,
                                               input longint w, input longint n,
                                               input longint s, input longint a,
                                               input longint b);
        longint dx;
        longint dy;
        longint adv;
        longint adv_term;
        longint lap;
        longint diff_term;
        // A velocity of exactly zero takes the downwind-side difference.
        dx = clamp_q(a > 0 ? c - w : e - c);
        dy = clamp_q(b > 0 ? c - s : n - c);
        adv = clamp_q(round_shift(clamp_q(a) * dx, 16) + round_shift(clamp_q(b) * dy, 16));
        // The advection weight is applied doubled, hence the shift by 15.
        adv_term = round_shift(longint'(adv_w) * adv, 15);
        lap = clamp_q(e + n + w + s - 4 * c);
        diff_term = round_shift(longint'(diff_w) * lap, 16);
        return adv_term + diff_term;
    endfunction

    function automatic velocity_t predict_velocity();
        longint    a;
        longint    b;
        longint    next_u;
        longint    next_v;
        velocity_t r;
        a = longint'(u_center) + longint'(fs_x);
        b = longint'(v_center) + longint'(fs_y);
        next_u = longint'(prev_u) - upwind_operator(u_center, u_east, u_west, u_north,
                                                    u_south, a, b);
        next_v = longint'(prev_v) - upwind_operator(v_center, v_east, v_west, v_north,
                                                    v_south, a, b);
        if (implicit_mode)
        begin
            next_u = next_u - longint'(u_center);
            next_v = next_v - longint'(v_center);
        end
        r.u = 32'(clamp_q(next_u));
        r.v = 32'(clamp_q(next_v));
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_x          <= '0;
            fs_y          <= '0;
            adv_w         <= '0;
            diff_w        <= '0;
            implicit_mode <= 1'b0;
            expected_velocity_q.delete();
            outstanding   <= 0;
            failures      <= 0;
        end
        else
        begin
            new_errors = 0;
            // The prediction uses the registers as they stand before this edge.
            if (start && !busy)
            begin
                expected_velocity_q.push_back(predict_velocity());
            end
            if (done)
            begin
                if (expected_velocity_q.size() == 0)
                begin
                    $error("result with no transaction outstanding: out_u %0d, out_v %0d",
                           out_u, out_v);
                    new_errors++;
                end
                else
                begin
                    want = expected_velocity_q.pop_front();
                    if (out_u !== want.u)
                    begin
                        $error("out_u: expected %0d, actual %0d", want.u, out_u);
                        new_errors++;
                    end
                    if (out_v !== want.v)
                    begin
                        $error("out_v: expected %0d, actual %0d", want.v, out_v);
                        new_errors++;
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FREE_STREAM_X: fs_x <= cfg_data;
                    CFG_FREE_STREAM_Y: fs_y <= cfg_data;
                    CFG_ADV_FACTOR:    adv_w <= cfg_data;
                    CFG_DIFF_FACTOR:   diff_w <= cfg_data;
                    CFG_UPDATE_MODE:   implicit_mode <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            outstanding <= expected_velocity_q.size();
            failures    <= failures + new_errors;
        end
    end

endmodule

### tb/sv/upwind_advection_diffusion_stencil_test.sv
`timescale 1ns / 1ps

module upwind_advection_diffusion_stencil_test import uads_pkg::*;
;

    typedef struct packed {
        logic signed [31:0] u_center;
        logic signed [31:0] u_east;
        logic signed [31:0] u_west;
        logic signed [31:0] u_north;
        logic signed [31:0] u_south;
        logic signed [31:0] v_center;
        logic signed [31:0] v_east;
        logic signed [31:0] v_west;
        logic signed [31:0] v_north;
        logic signed [31:0] v_south;
        logic signed [31:0] prev_u;
        logic signed [31:0] prev_v;
    } stencil_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic signed [31:0]    u_center = '0;
    logic signed [31:0]    u_east = '0;
    logic signed [31:0]    u_west = '0;
    logic signed [31:0]    u_north = '0;
    logic signed [31:0]    u_south = '0;
    logic signed [31:0]    v_center = '0;
    logic signed [31:0]    v_east = '0;
    logic signed [31:0]    v_west = '0;
    logic signed [31:0]    v_north = '0;
    logic signed [31:0]    v_south = '0;
    logic signed [31:0]    prev_u = '0;
    logic signed [31:0]    prev_v = '0;
    logic                  done;
    logic signed [31:0]    out_u;
    logic signed [31:0]    out_v;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_FREE_STREAM_X;
    logic [31:0]           cfg_data = '0;
    int unsigned           outstanding;
    int unsigned           failures;

    // Free-stream velocities currently programmed, used to aim at zero advecting velocity.
    logic signed [31:0]    cur_fs_x = '0;
    logic signed [31:0]    cur_fs_y = '0;
    logic                  steady = 1'b0;

    upwind_advection_diffusion_stencil dut (.*);

    upwind_stencil_checker checker_i (.*);

    always #6 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("upwind_advection_diffusion_stencil_test: errors");
        $finish;
    end

    function automatic logic signed [31:0] scatter(input logic signed [31:0] base,
                                                   input int unsigned spread);
        return base + (int'($urandom_range(0, 2 * spread)) - int'(spread));
    endfunction

    function automatic logic signed [31:0] edge_value();
        case ($urandom_range(0, 6))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return 32'sd0;
            3: return 32'sd1;
            4: return -32'sd1;
            5: return Q_MAX - 32'sd1;
            default: return $urandom();
        endcase
    endfunction

    function automatic stencil_t noise_point();
        stencil_t p;
        for (int i = 0; i < 12; i++)
        begin
            p[i*32 +: 32] = $urandom();
        end
        return p;
    endfunction

    // A smooth patch of flow: neighbors and previous value close to the center.
    function automatic stencil_t smooth_point();
        stencil_t           p;
        logic signed [31:0] bu;
        logic signed [31:0] bv;
        bu = scatter(0, 32'h0008_0000);
        bv = scatter(0, 32'h0008_0000);
        p.u_center = bu;
        p.u_east   = scatter(bu, 32'h0001_0000);
        p.u_west   = scatter(bu, 32'h0001_0000);
        p.u_north  = scatter(bu, 32'h0001_0000);
        p.u_south  = scatter(bu, 32'h0001_0000);
        p.v_center = bv;
        p.v_east   = scatter(bv, 32'h0001_0000);
        p.v_west   = scatter(bv, 32'h0001_0000);
        p.v_north  = scatter(bv, 32'h0001_0000);
        p.v_south  = scatter(bv, 32'h0001_0000);
        p.prev_u   = scatter(bu, 32'h0000_4000);
        p.prev_v   = scatter(bv, 32'h0000_4000);
        return p;
    endfunction

    function automatic stencil_t random_point();
        stencil_t    p;
        int unsigned kind;
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            p = smooth_point();
        end
        else if (kind < 55)
        begin
            p = smooth_point();
            if ($urandom_range(0, 2) != 2)
            begin
                p.u_center = -cur_fs_x;
            end
            if ($urandom_range(0, 2) != 1)
            begin
                p.v_center = -cur_fs_y;
            end
        end
        else if (kind < 70)
        begin
            for (int i = 0; i < 12; i++)
            begin
                p[i*32 +: 32] = edge_value();
            end
        end
        else if (kind < 90)
        begin
            p = noise_point();
        end
        else
        begin
            for (int i = 0; i < 12; i++)
            begin
                p[i*32 +: 32] = scatter(0, 4);
            end
        end
        return p;
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    task automatic drive_fields(input stencil_t p);
        u_center <= p.u_center;
        u_east   <= p.u_east;
        u_west   <= p.u_west;
        u_north  <= p.u_north;
        u_south  <= p.u_south;
        v_center <= p.v_center;
        v_east   <= p.v_east;
        v_west   <= p.v_west;
        v_north  <= p.v_north;
        v_south  <= p.v_south;
        prev_u   <= p.prev_u;
        prev_v   <= p.prev_v;
    endtask

    task automatic send_point(input stencil_t p);
        int unsigned gap;
        drive_fields(p);
        start <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (busy);
        gap = pick_gap();
        if (gap != 0)
        begin
            // Junk on the payload while start is low must be ignored.
            start <= 1'b0;
            drive_fields(noise_point());
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic program_settings(input logic signed [31:0] fsx,
                                    input logic signed [31:0] fsy,
                                    input logic signed [31:0] adv,
                                    input logic signed [31:0] diff,
                                    input logic mode);
        logic [31:0] mode_word;
        mode_word = $urandom();
        mode_word[0] = mode;
        wait_idle();
        write_reg(CFG_FREE_STREAM_X, fsx);
        write_reg(CFG_FREE_STREAM_Y, fsy);
        write_reg(CFG_ADV_FACTOR, adv);
        write_reg(CFG_DIFF_FACTOR, diff);
        write_reg(CFG_UPDATE_MODE, mode_word);
        // An index past the last register must change nothing.
        write_reg(CFG_UPDATE_MODE + CFG_IDX_W'($urandom_range(1, 3)), $urandom());
        cfg_we <= 1'b0;
        cur_fs_x = fsx;
        cur_fs_y = fsy;
    endtask

    task automatic run_directed();
        stencil_t d;
        d = '0;
        send_point(d);
        d = smooth_point();
        d.u_center = -cur_fs_x;
        d.v_center = -cur_fs_y;
        send_point(d);
        d = smooth_point();
        d.u_center = 32'sh0003_0000;
        d.v_center = -32'sh0002_0000;
        send_point(d);
        d = smooth_point();
        d.u_center = -32'sh0003_0000;
        d.v_center = 32'sh0002_0000;
        send_point(d);
        d = {12{Q_MAX}};
        send_point(d);
        d = {12{Q_MIN}};
        send_point(d);
        d = {12{Q_MIN}};
        d.u_center = Q_MAX;
        d.v_center = Q_MAX;
        d.prev_u = '0;
        d.prev_v = '0;
        send_point(d);
        d = {12{Q_MAX}};
        d.u_center = Q_MIN;
        d.v_center = Q_MIN;
        d.prev_u = '0;
        d.prev_v = '0;
        send_point(d);
        // Large operators of either sign drive the outputs into saturation.
        d = {12{Q_MAX}};
        d.u_center = Q_MIN;
        d.v_center = Q_MIN;
        send_point(d);
        d = {12{Q_MIN}};
        d.u_center = Q_MAX;
        d.v_center = Q_MAX;
        send_point(d);
        d = {6{32'hAAAA_AAAA, 32'h5555_5555}};
        send_point(d);
        d = {6{32'h5555_5555, 32'hAAAA_AAAA}};
        send_point(d);
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Registers still at their reset values.
        repeat (8) send_point(random_point());

        program_settings(32'sh0001_8000, -32'sh0000_8000, 32'sh0000_4000,
                         -32'sh0000_199A, 1'b0);
        run_directed();
        program_settings(32'sh0001_8000, -32'sh0000_8000, 32'sh0000_4000,
                         -32'sh0000_199A, 1'b1);
        run_directed();

        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                2: program_settings(Q_MAX, Q_MIN, Q_MAX, Q_MIN, 1'b1);
                3: program_settings(Q_MIN, Q_MAX, Q_MIN, Q_MAX, 1'b0);
                4: program_settings('0, '0, '0, '0, 1'b1);
                5: program_settings($urandom(), $urandom(), $urandom(), $urandom(),
                                    1'($urandom_range(0, 1)));
                default: program_settings(scatter(0, 32'h0004_0000),
                                          scatter(0, 32'h0004_0000),
                                          scatter(0, 32'h0001_0000),
                                          scatter(0, 32'h0000_8000),
                                          1'(phase % 2));
            endcase
            steady = (phase % 3 == 1);
            repeat (116) send_point(random_point());
        end

        wait_idle();
        repeat (12) @(posedge clk);
        if (failures == 0)
        begin
            $display("upwind_advection_diffusion_stencil_test: clean");
        end
        else
        begin
            $display("upwind_advection_diffusion_stencil_test: errors");
        end
        $finish;
    end

endmodule

### upwind_advection_diffusion_stencil.f
design/uads_pkg.sv
design/uads_front.sv
design/uads_queue.sv
design/uads_back.sv
design/upwind_advection_diffusion_stencil.sv
tb/sv/upwind_stencil_checker.sv
tb/sv/upwind_advection_diffusion_stencil_test.sv
